FILE: rtl/fcrd_pkg.sv
// Shared constants, types and helper functions of the FAST corner raster detector.
package fcrd_pkg;

    // Geometry
    localparam int MAX_WIDTH   = 1024;
    localparam int RING_RADIUS = 3;
    localparam int WIN         = 2 * RING_RADIUS + 1;
    localparam int LINES       = 2 * RING_RADIUS;
    localparam int RING_LEN    = 16;
    localparam int RUN_LEN     = 12;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int CELL_W     = PIX_W + 1;
    localparam int THR_W      = 8;
    localparam int WID_W      = 11;
    localparam int HGT_W      = 16;
    localparam int CX_W       = 10;
    localparam int CY_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Column address and working widths for raster position
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int XW = (CW + 1 > WID_W) ? CW + 1 : WID_W;
    localparam int YW = HGT_W + 1;
    localparam int CNT_W = $clog2(RING_LEN + 1);

    // Register reset values
    localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(20);
    localparam logic [WID_W-1:0] WIDTH_RST     = WID_W'(640);
    localparam logic [HGT_W-1:0] HEIGHT_RST    = HGT_W'(480);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_WIDTH     = 2'd1,
        CFG_HEIGHT    = 2'd2
    } t_cfg_idx;

    // One stored sample: mask bit over grey value
    typedef logic [CELL_W-1:0] t_cell;
    // One column of the line stores, oldest line at index 0
    typedef logic [LINES-1:0][CELL_W-1:0] t_col;

    // Ring positions in window coordinates (row 0 oldest, column 0 oldest)
    localparam logic [2:0] RING_ROW [RING_LEN] = '{
        3'd0, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6,
        3'd6, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
    };
    localparam logic [2:0] RING_COL [RING_LEN] = '{
        3'd3, 3'd4, 3'd5, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4,
        3'd3, 3'd2, 3'd1, 3'd0, 3'd0, 3'd0, 3'd1, 3'd2
    };

    // True when RUN_LEN cyclically consecutive bits are set
    function automatic logic f_has_run(input logic [RING_LEN-1:0] k);
        logic [2*RING_LEN-1:0] dbl;
        logic                  hit;
        dbl = {k, k};
        hit = 1'b0;
        for (int s = 0; s < RING_LEN; s++) begin
            if (&dbl[s +: RUN_LEN]) hit = 1'b1;
        end
        return hit;
    endfunction

    // Population count as a sum of nibble counts
    function automatic logic [CNT_W-1:0] f_count(input logic [RING_LEN-1:0] k);
        logic [CNT_W-1:0] sum;
        logic [2:0]       part;
        sum = '0;
        for (int n = 0; n < RING_LEN / 4; n++) begin
            part = 3'(k[4*n]) + 3'(k[4*n+1]) + 3'(k[4*n+2]) + 3'(k[4*n+3]);
            sum  = sum + CNT_W'(part);
        end
        return sum;
    endfunction

endpackage

FILE: rtl/fcrd_pix_if.sv
// Pixel input channel: valid/ready with pixel, mask bit and frame start.
interface fcrd_pix_if import fcrd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             mask_bit;
    logic             frame_start;

    modport source (output valid, output pixel, output mask_bit, output frame_start,
                    input ready);
    modport sink   (input valid, input pixel, input mask_bit, input frame_start,
                    output ready);
endinterface

FILE: rtl/fcrd_res_if.sv
// Result output channel: valid/ready with the segment test outcome and coordinates.
interface fcrd_res_if import fcrd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            center_valid;
    logic            is_corner;
    logic            center_brighter;
    logic [CX_W-1:0] center_x;
    logic [CY_W-1:0] center_y;

    modport source (output valid, output center_valid, output is_corner,
                    output center_brighter, output center_x, output center_y,
                    input ready);
    modport sink   (input valid, input center_valid, input is_corner,
                    input center_brighter, input center_x, input center_y,
                    output ready);
endinterface

FILE: rtl/fcrd_cfg_if.sv
// Configuration write channel: valid/ready with register index and write data.
interface fcrd_cfg_if import fcrd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/fcrd_line_ram.sv
// Single-port-write, single-port-read RAM with registered read data.
module fcrd_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 54
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    // Read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/fast_corner_raster_detector.sv
// Top level of the FAST corner raster detector: raster tracking, window and segment test.
// Each accepted pixel passes the stage 1, window, ring, count and output registers in order.
// Throughput: one pixel per cycle unless the output stalls; the line store is read once
// in the accept cycle and written back once when the pixel moves into the window stage.
// Each stage has its own valid bit, so bubbles close up under output stalls.
// Reset: registers return to 20 / 640 / 480, raster counters to zero, pipeline empty.
// The line store is not cleared; the window is fully refilled before any test.
module fast_corner_raster_detector import fcrd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fcrd_cfg_if.sink    i_cfg,
    fcrd_pix_if.sink    i_pix,
    fcrd_res_if.source  o_res
);

    // Configuration registers
    logic [THR_W-1:0] r_threshold;
    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;

    // Raster counters
    logic [CW-1:0]    r_col;
    logic [HGT_W-1:0] r_row;

    // Stage valids and enables
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;
    logic in_fire, mv12;

    // Stage 1: position and line store read
    logic [CW-1:0]    r_x1;
    t_cell            r_px1;
    logic             r_cv1;
    logic [CX_W-1:0]  r_cx1;
    logic [CY_W-1:0]  r_cy1;
    logic             r_fwd;
    t_col             r_fwd_col;

    // Stage 2: window
    t_cell            r_win [WIN][WIN];
    logic             r_cv2;
    logic [CX_W-1:0]  r_cx2;
    logic [CY_W-1:0]  r_cy2;

    // Stage 3: ring classification
    logic [RING_LEN-1:0] r_br3, r_dk3;
    logic                r_test3, r_cv3;
    logic [CX_W-1:0]     r_cx3;
    logic [CY_W-1:0]     r_cy3;

    // Stage 4: count and run flags
    logic            r_gtb4, r_gtd4, r_runb4, r_rund4, r_test4, r_cv4;
    logic [CX_W-1:0] r_cx4;
    logic [CY_W-1:0] r_cy4;

    // Stage 5: output register
    logic            r_cval5, r_corner5, r_bright5;
    logic [CX_W-1:0] r_cx5;
    logic [CY_W-1:0] r_cy5;

    // Combinational signals
    logic [XW-1:0]    w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [XW-1:0]    x_cur, x_nxt;
    logic [YW-1:0]    y_cur, y_nxt;
    logic             cv_cur;
    logic [CX_W-1:0]  cx_cur;
    logic [CY_W-1:0]  cy_cur;
    logic [LINES*CELL_W-1:0] ram_rdata;
    t_col             col_line, col_new;
    logic [RING_LEN-1:0] br_n, dk_n;
    t_cell            centre;

    // Handshake: each stage loads when empty or when the next one moves on
    assign en5     = !r_v5 || o_res.ready;
    assign en4     = !r_v4 || en5;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign in_fire = i_pix.valid && en1;
    assign mv12    = r_v1 && en2;

    assign i_pix.ready = en1;
    assign i_cfg.ready = 1'b1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_THRESHOLD: r_threshold <= i_cfg.data[THR_W-1:0];
                CFG_WIDTH:     r_width     <= i_cfg.data[WID_W-1:0];
                CFG_HEIGHT:    r_height    <= i_cfg.data[HGT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Effective frame size with clamping
    always_comb begin
        if (XW'(r_width) < XW'(WIN))            w_eff = XW'(WIN);
        else if (XW'(r_width) > XW'(MAX_WIDTH)) w_eff = XW'(MAX_WIDTH);
        else                                    w_eff = XW'(r_width);
        h_eff = (r_height < HGT_W'(WIN)) ? HGT_W'(WIN) : r_height;
    end

    // Position of the incoming pixel and of the next one
    always_comb begin
        x_cur = i_pix.frame_start ? '0 : XW'(r_col);
        y_cur = i_pix.frame_start ? '0 : YW'(r_row);
        if (x_cur >= w_eff) begin
            x_cur = '0;
            y_cur = y_cur + YW'(1);
        end
        if (y_cur >= YW'(h_eff)) y_cur = '0;

        x_nxt = x_cur + XW'(1);
        y_nxt = y_cur;
        if (x_nxt >= w_eff) begin
            x_nxt = '0;
            y_nxt = y_cur + YW'(1);
            if (y_nxt >= YW'(h_eff)) y_nxt = '0;
        end

        cv_cur = (x_cur >= XW'(LINES)) && (y_cur >= YW'(LINES));
        cx_cur = cv_cur ? CX_W'(x_cur - XW'(RING_RADIUS)) : '0;
        cy_cur = cv_cur ? CY_W'(y_cur - YW'(RING_RADIUS)) : '0;
    end

    // Raster counters advance on every accepted pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_fire) begin
            r_col <= x_nxt[CW-1:0];
            r_row <= y_nxt[HGT_W-1:0];
        end
    end

    // Line store: read at accept, write back when the pixel enters the window
    fcrd_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (LINES * CELL_W)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (mv12),
        .i_waddr (r_x1),
        .i_wdata (col_new),
        .i_re    (in_fire),
        .i_raddr (x_cur[CW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Column from the store, bypassed when the previous pixel wrote the same column
    always_comb begin
        col_line = r_fwd ? r_fwd_col : t_col'(ram_rdata);
        for (int r = 0; r < LINES - 1; r++) col_new[r] = col_line[r+1];
        col_new[LINES-1] = r_px1;
    end

    // Stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_fwd <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_pix.valid;
            if (in_fire) r_fwd <= mv12 && (x_cur[CW-1:0] == r_x1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_x1      <= x_cur[CW-1:0];
            r_px1     <= {i_pix.mask_bit, i_pix.pixel};
            r_cv1     <= cv_cur;
            r_cx1     <= cx_cur;
            r_cy1     <= cy_cur;
            r_fwd_col <= col_new;
        end
    end

    // Stage 2: shift the window one column and load the new column
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (en2) r_v2 <= r_v1;
    end

    always_ff @(posedge i_clk) begin
        if (mv12) begin
            for (int r = 0; r < WIN; r++) begin
                for (int c = 0; c < WIN - 1; c++) r_win[r][c] <= r_win[r][c+1];
            end
            for (int r = 0; r < LINES; r++) r_win[r][WIN-1] <= col_line[r];
            r_win[WIN-1][WIN-1] <= r_px1;
            r_cv2 <= r_cv1;
            r_cx2 <= r_cx1;
            r_cy2 <= r_cy1;
        end
    end

    // Ring classification against the centre
    always_comb begin
        centre = r_win[RING_RADIUS][RING_RADIUS];
        for (int k = 0; k < RING_LEN; k++) begin
            br_n[k] = {1'b0, centre[PIX_W-1:0]} >
                      ({1'b0, r_win[RING_ROW[k]][RING_COL[k]][PIX_W-1:0]} +
                       {1'b0, r_threshold});
            dk_n[k] = {1'b0, r_win[RING_ROW[k]][RING_COL[k]][PIX_W-1:0]} >
                      ({1'b0, centre[PIX_W-1:0]} + {1'b0, r_threshold});
        end
    end

    // Stage 3 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (en3) r_v3 <= r_v2;
    end

    always_ff @(posedge i_clk) begin
        if (en3 && r_v2) begin
            r_br3   <= br_n;
            r_dk3   <= dk_n;
            r_test3 <= r_cv2 && centre[CELL_W-1];
            r_cv3   <= r_cv2;
            r_cx3   <= r_cx2;
            r_cy3   <= r_cy2;
        end
    end

    // Stage 4: more than RUN_LEN of a kind, and a contiguous run of that kind
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else if (en4) r_v4 <= r_v3;
    end

    always_ff @(posedge i_clk) begin
        if (en4 && r_v3) begin
            r_gtb4  <= f_count(r_br3) > CNT_W'(RUN_LEN);
            r_gtd4  <= f_count(r_dk3) > CNT_W'(RUN_LEN);
            r_runb4 <= f_has_run(r_br3);
            r_rund4 <= f_has_run(r_dk3);
            r_test4 <= r_test3;
            r_cv4   <= r_cv3;
            r_cx4   <= r_cx3;
            r_cy4   <= r_cy3;
        end
    end

    // Stage 5: corner decision into the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else if (en5) r_v5 <= r_v4;
    end

    always_ff @(posedge i_clk) begin
        if (en5 && r_v4) begin
            r_cval5   <= r_cv4;
            r_corner5 <= r_test4 && (r_gtb4 ? r_runb4 : (r_gtd4 && r_rund4));
            r_bright5 <= r_test4 && r_gtb4 && r_runb4;
            r_cx5     <= r_cx4;
            r_cy5     <= r_cy4;
        end
    end

    assign o_res.valid           = r_v5;
    assign o_res.center_valid    = r_cval5;
    assign o_res.is_corner       = r_corner5;
    assign o_res.center_brighter = r_bright5;
    assign o_res.center_x        = r_cx5;
    assign o_res.center_y        = r_cy5;

    // A corner is only reported for a centre inside the border
    a_corner_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.is_corner |-> o_res.center_valid)
        else $error("corner reported outside the tested area");

    // Brighter kind only accompanies a corner
    a_bright_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.center_brighter |-> o_res.is_corner)
        else $error("brighter flag without a corner");

    // A stage 1 request that cannot move keeps its column address
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && !en2 |=> r_v1 && $stable(r_x1))
        else $error("stage 1 request lost under stall");

    // A same-column request arms the bypass for the item entering stage 1
    a_fwd_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && mv12 && (x_cur[CW-1:0] == r_x1) |=> r_v1 && r_fwd)
        else $error("column bypass not taken on a same-column request");

endmodule

FILE: test/fast_corner_raster_detector_test.sv
`timescale 1ns / 100ps
// Testbench of the FAST corner raster detector: streamed rasters checked against a local model.
module fast_corner_raster_detector_test;
    import fcrd_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int MAX_CYCLES   = 2_000_000;
    localparam int DRAIN_CYCLES = 20;
    // index with no register behind it; writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [0:0] {
        SCENE_NOISE,
        SCENE_DOTS
    } t_scene;

    typedef struct packed {
        logic            center_valid;
        logic            is_corner;
        logic            center_brighter;
        logic [CX_W-1:0] center_x;
        logic [CY_W-1:0] center_y;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;

    fcrd_cfg_if cfg_bus ();
    fcrd_pix_if pix_bus ();
    fcrd_res_if res_bus ();

    fast_corner_raster_detector u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_res   (res_bus)
    );

    // Model copy of registers, line stores, window and raster position
    logic [THR_W-1:0] thr_reg;
    logic [WID_W-1:0] wid_reg;
    logic [HGT_W-1:0] hgt_reg;
    t_cell            line_mem [LINES][MAX_WIDTH];
    t_cell            win [WIN][WIN];
    int unsigned      col_pos;
    int unsigned      row_pos;

    // ring offsets from the centre, clockwise from straight above
    int arc_row_off [RING_LEN] = '{-3, -3, -2, -1, 0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3};
    int arc_col_off [RING_LEN] = '{0, 1, 2, 3, 3, 3, 2, 1, 0, -1, -2, -3, -3, -3, -2, -1};

    t_outcome pending_outcomes [$];
    t_outcome head_outcome;
    int       fail_count  = 0;
    longint   cycle_count = 0;
    bit       idle_on;
    bit       stall_on;
    int       stall_left  = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("fast_corner_raster_detector test failed");
            $finish;
        end
    end

    // True when RUN_LEN neighbouring ring positions, wrapping round, are all set
    function automatic bit has_arc(input logic [RING_LEN-1:0] kind_set);
        bit whole;
        for (int s = 0; s < RING_LEN; s++) begin
            whole = 1'b1;
            for (int n = 0; n < RUN_LEN; n++) begin
                if (!kind_set[(s + n) % RING_LEN]) whole = 1'b0;
            end
            if (whole) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the model by one pixel and return the segment test outcome
    function automatic t_outcome score_pixel(input logic [PIX_W-1:0] pix, input logic msk,
                                             input logic fs);
        int unsigned         w;
        int unsigned         h;
        int unsigned         x;
        int unsigned         y;
        int                  centre_v;
        int                  ring_v;
        int                  diff;
        int                  th;
        logic [RING_LEN-1:0] brighter_set;
        logic [RING_LEN-1:0] darker_set;
        t_cell               centre;
        t_outcome            o;
        w = wid_reg;
        if (w < WIN) w = WIN;
        else if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = hgt_reg;
        if (h < WIN) h = WIN;
        x = col_pos;
        y = row_pos;
        if (fs) begin
            x = 0;
            y = 0;
        end
        // counters left beyond a shrunk raster
        if (x >= w) begin
            x = 0;
            y++;
        end
        if (y >= h) y = 0;

        // shift window left, new column from the line stores and the pixel
        for (int r = 0; r < WIN; r++)
            for (int c = 0; c < WIN - 1; c++) win[r][c] = win[r][c + 1];
        for (int r = 0; r < LINES; r++) win[r][WIN - 1] = line_mem[r][x];
        win[WIN - 1][WIN - 1] = {msk, pix};
        for (int r = 0; r < LINES - 1; r++) line_mem[r][x] = line_mem[r + 1][x];
        line_mem[LINES - 1][x] = {msk, pix};

        o = '0;
        if (x >= LINES && y >= LINES) begin
            o.center_valid = 1'b1;
            o.center_x     = CX_W'(x - RING_RADIUS);
            o.center_y     = CY_W'(y - RING_RADIUS);
            centre         = win[RING_RADIUS][RING_RADIUS];
            if (centre[PIX_W]) begin
                centre_v = int'(centre[PIX_W-1:0]);
                th       = int'(thr_reg);
                for (int k = 0; k < RING_LEN; k++) begin
                    ring_v = int'(win[RING_RADIUS + arc_row_off[k]]
                                     [RING_RADIUS + arc_col_off[k]][PIX_W-1:0]);
                    diff            = centre_v - ring_v;
                    brighter_set[k] = diff > th;
                    darker_set[k]   = diff < -th;
                end
                if ($countones(brighter_set) > RUN_LEN && has_arc(brighter_set)) begin
                    o.is_corner       = 1'b1;
                    o.center_brighter = 1'b1;
                end else if ($countones(darker_set) > RUN_LEN && has_arc(darker_set)) begin
                    o.is_corner = 1'b1;
                end
            end
        end

        // raster position of the next pixel
        x++;
        if (x >= w) begin
            x = 0;
            y++;
            if (y >= h) y = 0;
        end
        col_pos = x;
        row_pos = y;
        return o;
    endfunction

    // Scene content: plain noise, or a flat background with sparse dots near and far
    // from the threshold
    function automatic logic [PIX_W-1:0] scene_pixel(input t_scene scene, input int bg);
        int v;
        int delta;
        if (scene == SCENE_NOISE) return PIX_W'($urandom_range(0, 255));
        v = bg + int'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 1) == 0) delta = 255;
            else delta = int'(thr_reg) + int'($urandom_range(0, 3)) - 1;
            v = ($urandom_range(0, 1) == 0) ? v + delta : v - delta;
        end
        if (v < 0) v = 0;
        else if (v > 255) v = 255;
        return PIX_W'(v);
    endfunction

    // Result check against the oldest expectation
    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("result with no request waiting");
                fail_count++;
            end else begin
                head_outcome = pending_outcomes.pop_front();
                check_field("center_valid", head_outcome.center_valid, res_bus.center_valid);
                check_field("is_corner", head_outcome.is_corner, res_bus.is_corner);
                check_field("center_brighter", head_outcome.center_brighter,
                            res_bus.center_brighter);
                check_field("center_x", head_outcome.center_x, res_bus.center_x);
                check_field("center_y", head_outcome.center_y, res_bus.center_y);
            end
        end
    end

    // Result side back-pressure in random bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            res_bus.ready = 1'b0;
            stall_left--;
        end else if (stall_on && $urandom_range(0, 11) == 0) begin
            res_bus.ready = 1'b0;
            stall_left    = $urandom_range(0, 8);
        end else begin
            res_bus.ready = 1'b1;
        end
    end

    // One pixel request, with an optional gap before it
    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic msk, input logic fs);
        int       gap;
        t_outcome expected;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            @(negedge i_clk);
            pix_bus.valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pix_bus.valid       = 1'b1;
        pix_bus.pixel       = pix;
        pix_bus.mask_bit    = msk;
        pix_bus.frame_start = fs;
        do @(posedge i_clk); while (!pix_bus.ready);
        expected         = score_pixel(pix, msk, fs);
        pending_outcomes = {pending_outcomes, expected};
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_results;
        @(negedge i_clk);
        pix_bus.valid = 1'b0;
        while (pending_outcomes.size() != 0) @(negedge i_clk);
    endtask

    // One register write; the model takes it when the handshake completes
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            CFG_THRESHOLD: thr_reg = data[THR_W-1:0];
            CFG_WIDTH:     wid_reg = data[WID_W-1:0];
            CFG_HEIGHT:    hgt_reg = data[HGT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] thr,
                              input logic [CFG_DATA_W-1:0] wid,
                              input logic [CFG_DATA_W-1:0] hgt);
        wait_results;
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_WIDTH, wid);
        write_reg(CFG_HEIGHT, hgt);
    endtask

    // Raster of rows x cols pixels; start marks the first pixel, noisy scatters restarts
    task automatic send_frame(input t_scene scene, input int rows, input int cols,
                              input bit start, input bit noisy);
        int   bg;
        logic fs;
        bg = $urandom_range(30, 225);
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                fs = (start && r == 0 && c == 0) || (noisy && $urandom_range(0, 299) == 0);
                send_pixel(scene_pixel(scene, bg), $urandom_range(0, 7) != 0, fs);
            end
        end
    endtask

    // A 7x7 frame whose single tested window is built by hand:
    // ring positions picked by arc_sel get arc_val, the centre gets centre, everything else fill
    task automatic send_patch(input logic [PIX_W-1:0] centre, input logic centre_mask,
                              input logic [PIX_W-1:0] fill, input logic [PIX_W-1:0] arc_val,
                              input logic [RING_LEN-1:0] arc_sel);
        t_cell grid [WIN][WIN];
        for (int r = 0; r < WIN; r++)
            for (int c = 0; c < WIN; c++) grid[r][c] = {1'($urandom_range(0, 1)), fill};
        for (int k = 0; k < RING_LEN; k++) begin
            if (arc_sel[k])
                grid[RING_RADIUS + arc_row_off[k]][RING_RADIUS + arc_col_off[k]] =
                    {1'($urandom_range(0, 1)), arc_val};
        end
        grid[RING_RADIUS][RING_RADIUS] = {centre_mask, centre};
        for (int r = 0; r < WIN; r++)
            for (int c = 0; c < WIN; c++)
                send_pixel(grid[r][c][PIX_W-1:0], grid[r][c][PIX_W], r == 0 && c == 0);
    endtask

    // Threshold straight out of reset, with the width cut to a single window
    task automatic test_reset_config;
        idle_on  = 1'b1;
        stall_on = 1'b1;
        write_reg(CFG_WIDTH, 16'd7);
        send_patch(8'd128, 1'b1, 8'd128, 8'd149, 16'hFFFF); // one above the reset margin
        send_patch(8'd128, 1'b1, 8'd128, 8'd148, 16'hFFFF); // equal to the reset margin
    endtask

    // Hand-built windows on a 7x7 raster (sizes written as 0 act as 7)
    task automatic test_segment_cases;
        set_config(16'd0, 16'd0, 16'd0);
        send_patch(8'd255, 1'b1, 8'd0, 8'd0, '0);          // bright dot, zero margin
        send_patch(8'd0, 1'b1, 8'd255, 8'd255, '0);        // dark dot
        send_patch(8'd255, 1'b0, 8'd0, 8'd0, '0);          // masked centre
        wait_results;
        write_reg(CFG_THRESHOLD, 16'd20);
        send_patch(8'd128, 1'b1, 8'd128, 8'd200, 16'hFC7F); // arc of 13 across the wrap
        send_patch(8'd128, 1'b1, 8'd128, 8'd200, 16'hF0FF); // arc of exactly 12
        send_patch(8'd128, 1'b1, 8'd128, 8'd200, 16'hFBDE); // 13 darker, broken arc
        send_patch(8'd120, 1'b1, 8'd100, 8'd100, '0);      // difference equals margin
        send_patch(8'd121, 1'b1, 8'd100, 8'd100, '0);      // one above margin
        wait_results;
        write_reg(CFG_THRESHOLD, 16'h00FF);
        send_patch(8'd255, 1'b1, 8'd0, 8'd0, '0);          // full swing within top margin
    endtask

    // Upper data bits dropped, tallest height, spare index ignored
    task automatic test_width_limits;
        set_config(16'hFF1E, 16'hF807, 16'hFFFF);
        write_reg(CFG_SPARE, 16'hFFFF);
        send_frame(SCENE_NOISE, 9, WIN, 1'b1, 1'b0);
    endtask

    // Shrink the raster part way through a frame: column and row beyond the new size
    task automatic test_midframe_reconfig;
        set_config(16'd10, 16'd20, 16'd30);
        send_frame(SCENE_DOTS, 10, 20, 1'b1, 1'b0);
        send_frame(SCENE_DOTS, 1, 15, 1'b0, 1'b0);
        wait_results;
        write_reg(CFG_WIDTH, 16'd12);
        write_reg(CFG_HEIGHT, 16'd8);
        send_frame(SCENE_DOTS, 9, 12, 1'b0, 1'b0);
    endtask

    // Random frames with random settings, row wrap past the last row, stray restarts
    task automatic test_random_frames;
        int                    sent;
        int                    w;
        int                    h;
        int                    rows;
        logic [PIX_W-1:0]      thr;
        logic [CFG_DATA_W-1:0] wid;
        logic [CFG_DATA_W-1:0] hgt;
        sent = 0;
        while (sent < 300) begin
            idle_on  = $urandom_range(0, 3) != 0;
            stall_on = $urandom_range(0, 3) != 0;
            if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 7))
                    0:       thr = 8'd0;
                    1:       thr = 8'd255;
                    default: thr = PIX_W'($urandom_range(0, 60));
                endcase
                if ($urandom_range(0, 15) == 0) wid = CFG_DATA_W'($urandom_range(0, 6));
                else if ($urandom_range(0, 19) == 0) wid = CFG_DATA_W'($urandom_range(25, 80));
                else wid = CFG_DATA_W'($urandom_range(7, 24));
                if ($urandom_range(0, 7) == 0) hgt = CFG_DATA_W'($urandom_range(0, 6));
                else hgt = CFG_DATA_W'($urandom_range(7, 10));
                set_config({8'($urandom), thr}, wid, hgt);
            end
            w = (wid_reg < WIN) ? WIN : ((wid_reg > MAX_WIDTH) ? MAX_WIDTH : int'(wid_reg));
            h = (hgt_reg < WIN) ? WIN : int'(hgt_reg);
            rows = h + $urandom_range(0, 2);
            send_frame(t_scene'($urandom_range(0, 1)), rows, w, 1'b1, 1'b1);
            sent += rows * w;
        end
    endtask

    // Closing stretch at full rate on both sides
    task automatic test_back_to_back;
        idle_on  = 1'b0;
        stall_on = 1'b0;
        set_config(16'd15, 16'd9, 16'd8);
        send_frame(SCENE_DOTS, 10, 9, 1'b1, 1'b0);
    endtask

    initial begin
        i_rst_n             = 1'b0;
        pix_bus.valid       = 1'b0;
        pix_bus.pixel       = '0;
        pix_bus.mask_bit    = 1'b0;
        pix_bus.frame_start = 1'b0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = '0;
        cfg_bus.data        = '0;
        res_bus.ready       = 1'b0;
        idle_on             = 1'b0;
        stall_on            = 1'b0;

        // model at reset
        thr_reg = THRESHOLD_RST;
        wid_reg = WIDTH_RST;
        hgt_reg = HEIGHT_RST;
        col_pos = 0;
        row_pos = 0;
        for (int r = 0; r < WIN; r++)
            for (int c = 0; c < WIN; c++) win[r][c] = '0;
        for (int r = 0; r < LINES; r++)
            for (int c = 0; c < MAX_WIDTH; c++) line_mem[r][c] = '0;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_config;
        test_segment_cases;
        test_width_limits;
        test_midframe_reconfig;
        test_random_frames;
        test_back_to_back;

        wait_results;
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_outcomes.size() == 0) begin
            $display("fast_corner_raster_detector test passed");
        end else begin
            $display("fast_corner_raster_detector test failed");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/fcrd_pkg.sv
rtl/fcrd_pix_if.sv
rtl/fcrd_res_if.sv
rtl/fcrd_cfg_if.sv
rtl/fcrd_line_ram.sv
rtl/fast_corner_raster_detector.sv
test/fast_corner_raster_detector_test.sv
